### sv/vox_pkg.sv
package vox_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_HEAD      = 4'd0,
        PH_FIRST     = 4'd1,
        PH_PACK      = 4'd2,
        PH_SIZE_TAG  = 4'd3,
        PH_SIZE_BODY = 4'd4,
        PH_XYZI      = 4'd5,
        PH_VOXEL     = 4'd6,
        PH_IDLE      = 4'd7
    } phase_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_VOXEL      = 3'd0,
        KIND_DONE       = 3'd1,
        KIND_BAD_HEADER = 3'd2,
        KIND_NO_SIZE    = 3'd3,
        KIND_NO_XYZI    = 3'd4,
        KIND_TRUNCATED  = 3'd5
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_OFFSET_X = 2'd0;
    localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
    localparam logic [1:0] CFG_OFFSET_Z = 2'd2;

    // Little-endian tags as seen in the shift window
    localparam logic [31:0] TAG_VOX     = 32'h2058_4F56;
    localparam logic [31:0] TAG_PACK    = 32'h4B43_4150;
    localparam logic [31:0] TAG_SIZE    = 32'h455A_4953;
    localparam logic [31:0] TAG_XYZI    = 32'h495A_5958;
    localparam logic [31:0] VOX_VERSION = 32'd150;

    // Byte positions that close a field, and the position where a chunk body starts
    localparam logic [4:0] POS_TAG_END     = 5'd3;
    localparam logic [4:0] POS_VERSION_END = 5'd7;
    localparam logic [4:0] POS_HEADER_END  = 5'd19;
    localparam logic [4:0] POS_CHUNK_END   = 5'd15;
    localparam logic [4:0] POS_SIZE_END    = 5'd23;
    localparam logic [4:0] POS_BODY_START  = 5'd4;

    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_z;
    } offsets_t;

    typedef struct packed {
        kind_t              kind;
        logic [30:0]        frame_number;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [7:0]         color_index;
        logic               parse_end;
    } result_t;

endpackage

### sv/vox_voxel_stream_parser_core.sv
// Vox file stream parser.
// Input stream (s_*): one file byte per request in s_tdata, s_tlast on the
// final byte of the file. After s_tlast the parser rearms for a new file;
// the offset registers keep their values.
// Output stream (m_*): voxel, done and error results. m_tuser holds the
// kind, m_tlast marks the voxel that completes the final frame.
// Config port: cfg_we writes cfg_data into the offset selected by cfg_index
// (0 x, 1 y, 2 z); other indexes are dropped. Write only while idle.
// Throughput: one byte per cycle while s_tready is high; the byte is decoded
// in the cycle it is accepted and its result is registered in the output
// register, or in the skid register while the output is held.
// Stall: a two-entry output buffer (result register plus skid register)
// lets the parser take a byte while the receiver holds off; s_tready drops
// only once the skid register holds a result.
// Reset: all parse state returns to the header phase, offsets clear to
// zero and both output entries empty.
module vox_voxel_stream_parser_core
    import vox_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tlast,    // last_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // frame_number, pos_x, pos_y, pos_z, color_index, zero pad
    output logic [2:0]  m_tuser,    // kind
    output logic        m_tlast,    // parse_end
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    offsets_t offsets_reg;
    result_t  res;
    logic     res_valid;
    logic     accept;
    logic     out_free;

    result_t  out_reg;
    logic     out_valid_reg;
    result_t  skid_reg;
    logic     skid_valid_reg;

    // Offset registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offsets_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFSET_X: offsets_reg.offset_x <= cfg_data;
                CFG_OFFSET_Y: offsets_reg.offset_y <= cfg_data;
                CFG_OFFSET_Z: offsets_reg.offset_z <= cfg_data;
                default:
                begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    vox_byte_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .offsets   (offsets_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register with skid: advance when the head is free, otherwise
    // hold the new result in the skid register.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.parse_end;
    assign m_tdata  = {1'b0, out_reg.color_index, out_reg.pos_z, out_reg.pos_y,
                       out_reg.pos_x, out_reg.frame_number};

`ifndef SYNTH
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !skid_valid_reg && $past(skid_valid_reg) |-> $past(out_free))
        else $error("skid entry drained without output advance");
`endif

endmodule

### sv/vox_byte_parser.sv
module vox_byte_parser
    import vox_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  logic [7:0] data_byte,
    input  logic     last_byte,
    input  offsets_t offsets,
    output logic     res_valid,
    output result_t  res
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] window_reg, window_next;
    logic [31:0] frames_total_reg, frames_total_next;
    logic [30:0] frame_cnt_reg, frame_cnt_next;
    logic [31:0] voxels_left_reg, voxels_left_next;
    logic [23:0] record_reg, record_next;
    logic [30:0] frame_cnt_inc;
    logic        frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEAD;
            pos_reg          <= '0;
            window_reg       <= '0;
            frames_total_reg <= 32'd1;
            frame_cnt_reg    <= '0;
            voxels_left_reg  <= '0;
            record_reg       <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            window_reg       <= window_next;
            frames_total_reg <= frames_total_next;
            frame_cnt_reg    <= frame_cnt_next;
            voxels_left_reg  <= voxels_left_next;
            record_reg       <= record_next;
        end
    end

    assign frame_cnt_inc = frame_cnt_reg + 31'd1;

    always_comb
    begin
        window_next       = {data_byte, window_reg[31:8]};
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        frames_total_next = frames_total_reg;
        frame_cnt_next    = frame_cnt_reg;
        voxels_left_next  = voxels_left_reg;
        record_next       = record_reg;
        frame_end         = 1'b0;
        res_valid         = 1'b0;
        res               = '0;

        case (phase_reg)
            PH_HEAD:
            begin
                if ((pos_reg == POS_TAG_END && window_next != TAG_VOX) ||
                    (pos_reg == POS_VERSION_END && window_next != VOX_VERSION))
                begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_BAD_HEADER;
                    phase_next = PH_IDLE;
                end
                else if (pos_reg == POS_HEADER_END)
                begin
                    phase_next = PH_FIRST;
                    pos_next   = '0;
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
            PH_FIRST, PH_SIZE_TAG:
            begin
                if (pos_reg == POS_TAG_END)
                begin
                    if (phase_reg == PH_FIRST && window_next == TAG_PACK)
                    begin
                        phase_next = PH_PACK;
                        pos_next   = POS_BODY_START;
                    end
                    else if (window_next == TAG_SIZE)
                    begin
                        phase_next = PH_SIZE_BODY;
                        pos_next   = POS_BODY_START;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_NO_SIZE;
                        res.frame_number = frame_cnt_reg;
                        phase_next       = PH_IDLE;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
            PH_PACK:
            begin
                if (pos_reg == POS_CHUNK_END)
                begin
                    frames_total_next = window_next;
                    frame_cnt_next    = '0;
                    pos_next          = '0;
                    // zero or negative frame count: nothing to parse
                    if (window_next == '0 || window_next[31])
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_DONE;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_SIZE_TAG;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
            PH_SIZE_BODY:
            begin
                if (pos_reg == POS_SIZE_END)
                begin
                    phase_next = PH_XYZI;
                    pos_next   = '0;
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
            PH_XYZI:
            begin
                if (pos_reg == POS_TAG_END && window_next != TAG_XYZI)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_NO_XYZI;
                    res.frame_number = frame_cnt_reg;
                    phase_next       = PH_IDLE;
                end
                else if (pos_reg == POS_CHUNK_END)
                begin
                    voxels_left_next = window_next;
                    pos_next         = '0;
                    record_next      = '0;
                    if (window_next == '0)
                    begin
                        frame_end = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_VOXEL;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
            PH_VOXEL:
            begin
                case (pos_reg[1:0])
                    2'd0:
                    begin
                        record_next[7:0] = data_byte;
                        pos_next         = pos_reg + 5'd1;
                    end
                    2'd1:
                    begin
                        record_next[15:8] = data_byte;
                        pos_next          = pos_reg + 5'd1;
                    end
                    2'd2:
                    begin
                        record_next[23:16] = data_byte;
                        pos_next           = pos_reg + 5'd1;
                    end
                    default:
                    begin
                        // record is z, x, y, color
                        res_valid        = 1'b1;
                        res.kind         = KIND_VOXEL;
                        res.frame_number = frame_cnt_reg;
                        res.pos_x        = {8'd0, record_reg[15:8]} + offsets.offset_x;
                        res.pos_y        = {8'd0, record_reg[23:16]} + offsets.offset_y;
                        res.pos_z        = {8'd0, record_reg[7:0]} + offsets.offset_z;
                        res.color_index  = data_byte;
                        pos_next         = '0;
                        record_next      = '0;
                        voxels_left_next = voxels_left_reg - 32'd1;
                        if (voxels_left_reg == 32'd1)
                        begin
                            frame_end = 1'b1;
                        end
                    end
                endcase
            end
            default:
            begin
                // idle: drop bytes until the end of file
            end
        endcase

        if (frame_end)
        begin
            frame_cnt_next = frame_cnt_inc;
            if ({1'b0, frame_cnt_inc} == frames_total_reg)
            begin
                phase_next = PH_IDLE;
                if (res_valid)
                begin
                    res.parse_end = 1'b1;
                end
                else
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_DONE;
                    res.frame_number = frame_cnt_reg;
                end
            end
            else
            begin
                phase_next = PH_SIZE_TAG;
                pos_next   = '0;
            end
        end

        if (last_byte)
        begin
            if (phase_next != PH_IDLE)
            begin
                res_valid        = 1'b1;
                res              = '0;
                res.kind         = KIND_TRUNCATED;
                res.frame_number = frame_cnt_next;
            end
            // rearm for the next file
            phase_next        = PH_HEAD;
            pos_next          = '0;
            window_next       = '0;
            frames_total_next = 32'd1;
            frame_cnt_next    = '0;
            voxels_left_next  = '0;
            record_next       = '0;
        end

        if (!accept)
        begin
            res_valid = 1'b0;
        end
    end

`ifndef SYNTH
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> phase_reg == PH_HEAD && pos_reg == '0)
        else $error("parser did not rearm after end of file");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_IDLE && !last_byte |-> !res_valid)
        else $error("result while idle");

    a_voxel_src: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_VOXEL |-> phase_reg == PH_VOXEL && pos_reg == 5'd3)
        else $error("voxel result outside record end");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_SIZE_END)
        else $error("byte position out of range");
`endif

endmodule
